[src/hnm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package hnm_pkg;

	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	// one queue entry: everything the back end needs for one accepted item
	typedef struct packed {
		pixel_t     here;
		logic [7:0] right_red;
		pixel_t     pix;
		logic       has_above;
		logic       last_col;
		logic       last_row;
	} entry_t;

	typedef enum logic [1:0] {
		R_IDLE,
		R_DIV,
		R_ROOT,
		R_DONE
	} rsqrt_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_ROOT,
		B_MUL,
		B_EMIT_N,
		B_EMIT_A,
		B_EMIT_B
	} back_state_t;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	// 2^50 / s takes one quotient bit per step from bit 50 down
	localparam logic [5:0] DIV_LAST  = 6'd50;
	localparam logic [5:0] ROOT_LAST = 6'd17;
	localparam logic [34:0] ROOT_ONE = 35'h4_0000_0000;
	localparam logic [17:0] Z_SQ     = 18'd65025;

	// floor(255 * (2^24 + p) / 2^25) clamped to 0..255
	function automatic logic [7:0] norm_comp(input logic signed [26:0] p);
		logic signed [27:0] t;
		logic signed [35:0] m;
		t = 28'sd16777216 + 28'(p);
		m = (36'(t) <<< 8) - 36'(t);
		if (m < 0) begin
			norm_comp = 8'd0;
		end else if (|m[34:33]) begin
			norm_comp = 8'd255;
		end else begin
			norm_comp = m[32:25];
		end
	endfunction

endpackage
`default_nettype wire

[src/hnm_pix_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface hnm_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;
	logic [7:0] in_alpha;

	modport source (output valid, in_red, in_green, in_blue, in_alpha, input ready);
	modport sink (input valid, in_red, in_green, in_blue, in_alpha, output ready);
endinterface
`default_nettype wire

[src/hnm_res_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface hnm_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic [7:0] out_alpha;
	logic       run_last;
	logic       frame_done;

	modport source (output valid, out_red, out_green, out_blue, out_alpha, run_last,
		frame_done, input ready);
	modport sink (input valid, out_red, out_green, out_blue, out_alpha, run_last,
		frame_done, output ready);
endinterface
`default_nettype wire

[src/hnm_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module hnm_front #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	hnm_pix_if.sink              pixels,
	input  wire logic [11:0]     width,
	input  wire logic [15:0]     height,
	input  wire logic            full,
	output logic                 push,
	output hnm_pkg::entry_t      push_data
);
	localparam int XW  = $clog2(MAX_WIDTH);
	localparam int WCW = (XW + 1 > 12) ? XW + 1 : 12;

	logic [31:0]        mem [MAX_WIDTH];
	logic [31:0]        rd_q;
	logic [XW-1:0]      x_q;
	logic [15:0]        y_q;
	hnm_pkg::pixel_t    here_q;
	logic               v_s1;
	hnm_pkg::pixel_t    pix_s1;
	logic               last_col_s1, last_row_s1, has_above_s1, x_zero_s1;

	logic               acc;
	logic [WCW-1:0]     w_eff;
	logic [16:0]        h_eff;
	logic               last_col, last_row;
	logic [XW-1:0]      raddr;
	hnm_pkg::pixel_t    pix;

	assign pix = '{alpha: pixels.in_alpha, blue: pixels.in_blue,
		green: pixels.in_green, red: pixels.in_red};

	always_comb begin
		if (width == 12'd0) begin
			w_eff = WCW'(1);
		end else if (WCW'(width) > WCW'(MAX_WIDTH)) begin
			w_eff = WCW'(MAX_WIDTH);
		end else begin
			w_eff = WCW'(width);
		end
		h_eff = (height == 16'd0) ? 17'd1 : {1'b0, height};
	end

	assign last_col = (WCW'(x_q) + WCW'(1)) >= w_eff;
	assign last_row = ({1'b0, y_q} + 17'd1) >= h_eff;
	// right neighbor of the pixel above, or start of the stored line on a wrap
	assign raddr = last_col ? '0 : x_q + XW'(1);

	assign push         = v_s1 && !full;
	assign pixels.ready = !v_s1 || !full;
	assign acc          = pixels.valid && pixels.ready;

	assign push_data = '{here: here_q, right_red: rd_q[7:0], pix: pix_s1,
		has_above: has_above_s1, last_col: last_col_s1, last_row: last_row_s1};

	always_ff @(posedge clk) begin
		if (acc) begin
			mem[x_q] <= pix;
			rd_q     <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1       <= pix;
			last_col_s1  <= last_col;
			last_row_s1  <= last_row;
			has_above_s1 <= y_q != 16'd0;
			x_zero_s1    <= x_q == '0;
		end
		if (push) begin
			if (last_col_s1 && x_zero_s1) begin
				here_q <= pix_s1;
			end else begin
				here_q <= rd_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			x_q  <= '0;
			y_q  <= '0;
		end else begin
			if (acc) begin
				v_s1 <= 1'b1;
			end else if (push) begin
				v_s1 <= 1'b0;
			end
			if (acc) begin
				if (last_col) begin
					x_q <= '0;
					y_q <= last_row ? 16'd0 : y_q + 16'd1;
				end else begin
					x_q <= x_q + XW'(1);
				end
			end
		end
	end

endmodule
`default_nettype wire

[src/hnm_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
module hnm_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire hnm_pkg::entry_t push_data,
	input  wire logic            pop,
	output logic                 full,
	output logic                 nonempty,
	output hnm_pkg::entry_t      head
);
	hnm_pkg::entry_t slot_q [2];
	logic            wp_q, rp_q;
	logic [1:0]      cnt_q;

	assign full     = cnt_q == 2'd2;
	assign nonempty = cnt_q != 2'd0;
	assign head     = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty)
		else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("queue count out of range");

endmodule
`default_nettype wire

[src/hnm_rsqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
module hnm_rsqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [17:0] s,
	output logic             done,
	output logic [16:0]      r
);
	hnm_pkg::rsqrt_state_t state_q, state_d;
	logic [5:0]  cnt_q;
	logic [17:0] s_q, rem_q;
	logic [34:0] quo_q, op_q, res_q, one_q;

	logic [18:0] rem_sh;
	logic        div_ge;
	logic [34:0] sum;
	logic        root_ge;
	logic [18:0] t_inc;

	// restoring division of 2^50 by s, then bitwise integer square root
	assign rem_sh  = {rem_q, cnt_q == hnm_pkg::DIV_LAST};
	assign div_ge  = rem_sh >= {1'b0, s_q};
	assign sum     = res_q + one_q;
	assign root_ge = op_q >= sum;
	assign t_inc   = {1'b0, res_q[17:0]} + 19'd1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hnm_pkg::R_IDLE: if (start) state_d = hnm_pkg::R_DIV;
			hnm_pkg::R_DIV:  if (cnt_q == 6'd0) state_d = hnm_pkg::R_ROOT;
			hnm_pkg::R_ROOT: if (cnt_q == 6'd0) state_d = hnm_pkg::R_DONE;
			hnm_pkg::R_DONE: state_d = hnm_pkg::R_IDLE;
			default:         state_d = hnm_pkg::R_IDLE;
		endcase
	end

	always_comb begin
		done = state_q == hnm_pkg::R_DONE;
		r    = t_inc[17:1];
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			hnm_pkg::R_IDLE: begin
				s_q   <= s;
				rem_q <= '0;
				quo_q <= '0;
			end
			hnm_pkg::R_DIV: begin
				rem_q <= div_ge ? 18'(rem_sh - {1'b0, s_q}) : rem_sh[17:0];
				quo_q <= {quo_q[33:0], div_ge};
				if (cnt_q == 6'd0) begin
					op_q  <= {quo_q[33:0], div_ge};
					res_q <= '0;
					one_q <= hnm_pkg::ROOT_ONE;
				end
			end
			hnm_pkg::R_ROOT: begin
				if (root_ge) begin
					op_q  <= op_q - sum;
					res_q <= (res_q >> 1) + one_q;
				end else begin
					res_q <= res_q >> 1;
				end
				one_q <= one_q >> 2;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hnm_pkg::R_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == hnm_pkg::R_IDLE) begin
				cnt_q <= hnm_pkg::DIV_LAST;
			end else if (state_q == hnm_pkg::R_DIV && cnt_q == 6'd0) begin
				cnt_q <= hnm_pkg::ROOT_LAST;
			end else if (cnt_q != 6'd0) begin
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

endmodule
`default_nettype wire

[src/hnm_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module hnm_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            nonempty,
	input  wire hnm_pkg::entry_t head,
	output logic                 pop,
	hnm_res_if.source            results
);
	hnm_pkg::back_state_t state_q, state_d;
	hnm_pkg::entry_t      e_q;
	logic signed [8:0]    a_q, b_q;
	logic [16:0]          r_q;
	logic signed [26:0]   pa_q, pb_q, pc_q;
	logic                 out_v_q;
	hnm_pkg::pixel_t      out_q;
	logic                 run_last_q, done_q;

	logic signed [8:0]    a, b;
	logic [17:0]          s;
	logic                 start, rs_done;
	logic [16:0]          rs_r;
	logic                 out_free, load;
	hnm_pkg::pixel_t      load_pix;
	logic                 load_last, load_done;

	assign a = $signed({1'b0, head.right_red}) - $signed({1'b0, head.here.red});
	assign b = $signed({1'b0, head.pix.red}) - $signed({1'b0, head.here.red});
	// squares taken at full width so the products keep all their bits
	assign s = 18'(a) * 18'(a) + 18'(b) * 18'(b) + hnm_pkg::Z_SQ;

	hnm_rsqrt u_rsqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.s      (s),
		.done   (rs_done),
		.r      (rs_r)
	);

	assign out_free = !out_v_q || results.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hnm_pkg::B_IDLE: begin
				if (nonempty) begin
					if (head.has_above && !head.last_col) state_d = hnm_pkg::B_ROOT;
					else if (head.has_above)             state_d = hnm_pkg::B_EMIT_A;
					else if (head.last_row)              state_d = hnm_pkg::B_EMIT_B;
				end
			end
			hnm_pkg::B_ROOT: if (rs_done) state_d = hnm_pkg::B_MUL;
			hnm_pkg::B_MUL:  state_d = hnm_pkg::B_EMIT_N;
			hnm_pkg::B_EMIT_N, hnm_pkg::B_EMIT_A: begin
				if (out_free) state_d = e_q.last_row ? hnm_pkg::B_EMIT_B : hnm_pkg::B_IDLE;
			end
			hnm_pkg::B_EMIT_B: if (out_free) state_d = hnm_pkg::B_IDLE;
			default: state_d = hnm_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		start     = 1'b0;
		load      = 1'b0;
		load_pix  = e_q.pix;
		load_last = 1'b1;
		load_done = 1'b0;
		unique case (state_q)
			hnm_pkg::B_IDLE: begin
				pop   = nonempty;
				start = nonempty && head.has_above && !head.last_col;
			end
			hnm_pkg::B_EMIT_N: begin
				load      = out_free;
				load_pix  = '{alpha: 8'd255, blue: hnm_pkg::norm_comp(pc_q),
					green: hnm_pkg::norm_comp(pb_q), red: hnm_pkg::norm_comp(pa_q)};
				load_last = !e_q.last_row;
			end
			hnm_pkg::B_EMIT_A: begin
				load      = out_free;
				load_pix  = e_q.here;
				load_last = !e_q.last_row;
			end
			hnm_pkg::B_EMIT_B: begin
				load      = out_free;
				load_done = e_q.last_col;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			e_q <= head;
			a_q <= a;
			b_q <= b;
		end
		if (rs_done) begin
			r_q <= rs_r;
		end
		if (state_q == hnm_pkg::B_MUL) begin
			pa_q <= 27'(a_q) * 27'($signed({1'b0, r_q}));
			pb_q <= 27'(b_q) * 27'($signed({1'b0, r_q}));
			pc_q <= $signed({2'b00, r_q, 8'd0}) - $signed({10'd0, r_q});
		end
		if (load) begin
			out_q      <= load_pix;
			run_last_q <= load_last;
			done_q     <= load_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hnm_pkg::B_IDLE;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_v_q <= 1'b1;
			end else if (results.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign results.valid      = out_v_q;
	assign results.out_red    = out_q.red;
	assign results.out_green  = out_q.green;
	assign results.out_blue   = out_q.blue;
	assign results.out_alpha  = out_q.alpha;
	assign results.run_last   = run_last_q;
	assign results.frame_done = done_q;

endmodule
`default_nettype wire

[src/height_to_normal_map_unit.sv]
// Height image to normal map. RGBA pixels enter in raster order on "pixels";
// the red channel is the height. One line is kept in an internal RAM of
// MAX_WIDTH words, so results lag by one row: each pixel of row y releases the
// result for the pixel above it, and each pixel of the last row also yields
// its own pass-through result right after. Interior pixels give the normal
// (x, y, z, 255) from forward differences; last-column and last-row pixels
// come out unchanged. The front end takes one pixel per cycle into a two-entry
// queue while that queue is not full. For an interior normal the back end
// takes the item, runs a one-bit-per-cycle divider and then a square-root
// unit, hands over the root, does the multiplies and loads the result; other
// items are taken and give their pass-through results without that unit, so
// the sustained rate is set by that reciprocal square root unit; a stalled
// output adds its stall cycles. Width (register 0, reset 2048, 0 reads as 1,
// clipped to MAX_WIDTH) and height (register 1, reset 1, 0 reads as 1) must
// only be written while the block is idle. The line RAM has no reset; row 0
// of a frame fills it before its contents are used.
`timescale 1ns / 1ps
`default_nettype none
module height_to_normal_map_unit #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_wdata,
	hnm_pix_if.sink          pixels,
	hnm_res_if.source        results
);
	// configuration registers
	logic [11:0] width_q;
	logic [15:0] height_q;

	// front to back queue
	logic            push, pop, full, nonempty;
	hnm_pkg::entry_t push_data, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 12'd2048;
			height_q <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hnm_pkg::CFG_WIDTH:  width_q  <= cfg_wdata[11:0];
				hnm_pkg::CFG_HEIGHT: height_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// position tracking, line RAM and neighbor fetch
	hnm_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixels    (pixels),
		.width     (width_q),
		.height    (height_q),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	// short queue lets the front keep taking items while the back computes
	hnm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (full),
		.nonempty  (nonempty),
		.head      (head)
	);

	// normal math and result sequencing, with its own output register
	hnm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.nonempty (nonempty),
		.head     (head),
		.pop      (pop),
		.results  (results)
	);

endmodule
`default_nettype wire
